FILE: src/chacha20_stream_cipher_top_assert.svh
// Assertion macros shared by the cipher modules.
`ifndef CHACHA20_STREAM_CIPHER_TOP_ASSERT_SVH
`define CHACHA20_STREAM_CIPHER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CC20_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("cc20 assertion failed");

// Next-cycle implication, checked outside reset.
`define CC20_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("cc20 assertion failed");

`endif

FILE: src/cc20_pkg.sv
// Shared types and constants of the ChaCha20 stream cipher.
package cc20_pkg;

	localparam int unsigned WORD_W        = 32;
	localparam int unsigned NUM_WORDS     = 16;
	localparam int unsigned DOUBLE_ROUNDS = 10;
	localparam int unsigned HALF_ROUNDS   = 2 * DOUBLE_ROUNDS;
	localparam int unsigned HALF_W        = $clog2(HALF_ROUNDS);
	localparam int unsigned CFG_DATA_W    = 64;
	localparam int unsigned CFG_IDX_W     = 3;
	localparam int unsigned POS_W         = 6;

	localparam logic [WORD_W-1:0] SIGMA_0 = 32'h61707865;
	localparam logic [WORD_W-1:0] SIGMA_1 = 32'h3320646e;
	localparam logic [WORD_W-1:0] SIGMA_2 = 32'h79622d32;
	localparam logic [WORD_W-1:0] SIGMA_3 = 32'h6b206574;

	localparam int unsigned ROT_A = 16;
	localparam int unsigned ROT_B = 12;
	localparam int unsigned ROT_C = 8;
	localparam int unsigned ROT_D = 7;

	localparam logic [CFG_IDX_W-1:0] REG_KEY_0_7   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_8_15  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_16_23 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_24_31 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_NONCE_0_7 = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_NONCE_8_11 = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_INIT_CTR  = 3'd6;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOAD,
		S_ROUND,
		S_FINAL,
		S_EMIT
	} ctrl_state_t;

	// The four dependent steps of a quarter-round.
	typedef enum logic [1:0] {
		STEP_AD16,
		STEP_CB12,
		STEP_AD8,
		STEP_CB7
	} qr_step_t;

	typedef struct packed {
		logic     accept;
		logic     load;
		logic     step;
		qr_step_t step_sel;
		logic     diag;
		logic     final_add;
		logic     emit;
	} cc20_cmd_t;

	typedef struct packed {
		logic need_block;
		logic out_free;
	} cc20_status_t;

endpackage

FILE: src/chacha20_stream_cipher_top.sv
// Top level of the ChaCha20 stream cipher.
// A byte inside a keystream block is accepted, then emitted to the output register; a byte
// at a block start first passes load, 80 quarter-round steps (one add-xor-rotate
// per lane per cycle), final add and output.
// A new byte is taken only after the previous one is emitted; emit waits for the output.
// Reset (arst_n low) clears configuration, counters and handshake; keystream is regenerated.
module chacha20_stream_cipher_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [7:0]                      s_tdata,   // [7:0] data_in
	input  logic                            s_tlast,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [7:0]                      m_tdata,   // [7:0] data_out
	output logic                            m_tlast,
	input  logic                            cfg_wen,
	input  logic [cc20_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [cc20_pkg::CFG_DATA_W-1:0] cfg_data
);

	cc20_pkg::cc20_cmd_t    cmd;
	cc20_pkg::cc20_status_t st;

	cc20_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	cc20_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wen  (cfg_wen),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.cmd      (cmd),
		.st       (st)
	);

endmodule

FILE: src/cc20_ctrl.sv
// Sequencer for the cipher: item handshake and the block round schedule.
`include "chacha20_stream_cipher_top_assert.svh"

module cc20_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  cc20_pkg::cc20_status_t st,
	output cc20_pkg::cc20_cmd_t    cmd
);

	cc20_pkg::ctrl_state_t state_q, state_d;
	logic [1:0]                  step_q;
	logic [cc20_pkg::HALF_W-1:0] half_q;
	logic                        rounds_done;

	assign rounds_done = (step_q == 2'd3) &&
		(half_q == cc20_pkg::HALF_W'(cc20_pkg::HALF_ROUNDS - 1));

	always_comb begin
		state_d = state_q;
		case (state_q)
			cc20_pkg::S_IDLE: begin
				if (s_tvalid) begin
					state_d = st.need_block ? cc20_pkg::S_LOAD : cc20_pkg::S_EMIT;
				end
			end
			cc20_pkg::S_LOAD:  state_d = cc20_pkg::S_ROUND;
			cc20_pkg::S_ROUND: begin
				if (rounds_done) begin
					state_d = cc20_pkg::S_FINAL;
				end
			end
			cc20_pkg::S_FINAL: state_d = cc20_pkg::S_EMIT;
			cc20_pkg::S_EMIT: begin
				if (st.out_free) begin
					state_d = cc20_pkg::S_IDLE;
				end
			end
			default: state_d = cc20_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		s_tready       = 1'b0;
		cmd            = '0;
		cmd.step_sel   = cc20_pkg::qr_step_t'(step_q);
		cmd.diag       = half_q[0];
		case (state_q)
			cc20_pkg::S_IDLE: begin
				s_tready   = 1'b1;
				cmd.accept = s_tvalid;
			end
			cc20_pkg::S_LOAD:  cmd.load      = 1'b1;
			cc20_pkg::S_ROUND: cmd.step      = 1'b1;
			cc20_pkg::S_FINAL: cmd.final_add = 1'b1;
			cc20_pkg::S_EMIT:  cmd.emit      = st.out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cc20_pkg::S_IDLE;
			step_q  <= '0;
			half_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == cc20_pkg::S_ROUND) begin
				step_q <= step_q + 2'd1;
				if (step_q == 2'd3) begin
					half_q <= rounds_done ? '0 : half_q + cc20_pkg::HALF_W'(1);
				end
			end
		end
	end

	`CC20_ASSERT_NOW(a_cnt_idle, clk, arst_n, state_q != cc20_pkg::S_ROUND, (step_q == 2'd0) && (half_q == '0))
	`CC20_ASSERT_NEXT(a_block_start, clk, arst_n, cmd.accept && st.need_block, state_q == cc20_pkg::S_LOAD)
	`CC20_ASSERT_NEXT(a_emit_wait, clk, arst_n, (state_q == cc20_pkg::S_EMIT) && !st.out_free, state_q == cc20_pkg::S_EMIT)

endmodule

FILE: src/cc20_dp.sv
// Datapath: configuration, block state, quarter-round lanes and output register.
`include "chacha20_stream_cipher_top_assert.svh"

module cc20_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wen,
	input  logic [cc20_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [cc20_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic [7:0]                          s_tdata,
	input  logic                                s_tlast,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [7:0]                          m_tdata,
	output logic                                m_tlast,
	input  cc20_pkg::cc20_cmd_t                 cmd,
	output cc20_pkg::cc20_status_t              st
);

	localparam int unsigned W = cc20_pkg::WORD_W;

	logic [63:0]  key0_q, key1_q, key2_q, key3_q, nonce0_q;
	logic [W-1:0] nonce1_q, ictr_q, blk_ctr_q, ctr_sel;
	logic [cc20_pkg::POS_W-1:0] pos_q;
	logic         msg_start_q;
	logic [7:0]   data_q;
	logic         last_q;
	logic         out_valid_q;
	logic [7:0]   out_data_q;
	logic         out_last_q;

	// Working state; after the final add it holds the keystream block.
	logic [W-1:0] work_q [cc20_pkg::NUM_WORDS];
	logic [W-1:0] init_w [cc20_pkg::NUM_WORDS];
	logic [W-1:0] step_w [cc20_pkg::NUM_WORDS];
	logic [W-1:0] ks_word;
	logic [7:0]   ks_byte;

	function automatic logic [W-1:0] rotl_step(input logic [W-1:0] v,
			input cc20_pkg::qr_step_t sel);
		logic [W-1:0] r;
		begin
			case (sel)
				cc20_pkg::STEP_AD16: r = (v << cc20_pkg::ROT_A) | (v >> (W - cc20_pkg::ROT_A));
				cc20_pkg::STEP_CB12: r = (v << cc20_pkg::ROT_B) | (v >> (W - cc20_pkg::ROT_B));
				cc20_pkg::STEP_AD8:  r = (v << cc20_pkg::ROT_C) | (v >> (W - cc20_pkg::ROT_C));
				cc20_pkg::STEP_CB7:  r = (v << cc20_pkg::ROT_D) | (v >> (W - cc20_pkg::ROT_D));
				default:             r = v;
			endcase
			return r;
		end
	endfunction

	// On a message start the block counter comes from the start-counter register.
	assign ctr_sel = msg_start_q ? ictr_q : blk_ctr_q;

	always_comb begin
		init_w[0]  = cc20_pkg::SIGMA_0;
		init_w[1]  = cc20_pkg::SIGMA_1;
		init_w[2]  = cc20_pkg::SIGMA_2;
		init_w[3]  = cc20_pkg::SIGMA_3;
		init_w[4]  = key0_q[31:0];
		init_w[5]  = key0_q[63:32];
		init_w[6]  = key1_q[31:0];
		init_w[7]  = key1_q[63:32];
		init_w[8]  = key2_q[31:0];
		init_w[9]  = key2_q[63:32];
		init_w[10] = key3_q[31:0];
		init_w[11] = key3_q[63:32];
		init_w[12] = ctr_sel;
		init_w[13] = nonce0_q[31:0];
		init_w[14] = nonce0_q[63:32];
		init_w[15] = nonce1_q;
	end

	// One step of four quarter-rounds in parallel. Rows sit at words 0, 4, 8
	// and 12; a diagonal round shifts rows B, C and D by one, two and three.
	always_comb begin
		logic [1:0]   lane;
		logic [3:0]   xi, yi, zi;
		logic [W-1:0] sum, mix;
		step_w = work_q;
		for (int j = 0; j < 4; j++) begin
			lane = 2'(j);
			if (cmd.step_sel == cc20_pkg::STEP_AD16 || cmd.step_sel == cc20_pkg::STEP_AD8) begin
				xi = {2'b00, lane};
				yi = {2'b01, lane + {1'b0, cmd.diag}};
				zi = {2'b11, lane + {cmd.diag, cmd.diag}};
			end else begin
				xi = {2'b10, lane + {cmd.diag, 1'b0}};
				yi = {2'b11, lane + {cmd.diag, cmd.diag}};
				zi = {2'b01, lane + {1'b0, cmd.diag}};
			end
			sum        = work_q[xi] + work_q[yi];
			mix        = work_q[zi] ^ sum;
			step_w[xi] = sum;
			step_w[zi] = rotl_step(mix, cmd.step_sel);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			work_q <= init_w;
		end else if (cmd.step) begin
			work_q <= step_w;
		end else if (cmd.final_add) begin
			for (int i = 0; i < cc20_pkg::NUM_WORDS; i++) begin
				work_q[i] <= work_q[i] + init_w[i];
			end
		end
	end

	assign ks_word = work_q[pos_q[5:2]];
	assign ks_byte = ks_word[{pos_q[1:0], 3'b000} +: 8];

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			data_q <= s_tdata;
			last_q <= s_tlast;
		end
		if (cmd.emit) begin
			out_data_q <= data_q ^ ks_byte;
			out_last_q <= last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key0_q      <= '0;
			key1_q      <= '0;
			key2_q      <= '0;
			key3_q      <= '0;
			nonce0_q    <= '0;
			nonce1_q    <= '0;
			ictr_q      <= '0;
			blk_ctr_q   <= '0;
			pos_q       <= '0;
			msg_start_q <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wen) begin
				case (cfg_idx)
					cc20_pkg::REG_KEY_0_7:    key0_q   <= cfg_data;
					cc20_pkg::REG_KEY_8_15:   key1_q   <= cfg_data;
					cc20_pkg::REG_KEY_16_23:  key2_q   <= cfg_data;
					cc20_pkg::REG_KEY_24_31:  key3_q   <= cfg_data;
					cc20_pkg::REG_NONCE_0_7:  nonce0_q <= cfg_data;
					cc20_pkg::REG_NONCE_8_11: nonce1_q <= cfg_data[W-1:0];
					cc20_pkg::REG_INIT_CTR:   ictr_q   <= cfg_data[W-1:0];
					default: ;
				endcase
			end
			if (cmd.load) begin
				blk_ctr_q   <= ctr_sel;
				msg_start_q <= 1'b0;
			end
			if (cmd.final_add) begin
				blk_ctr_q <= blk_ctr_q + W'(1);
			end
			if (cmd.emit) begin
				pos_q <= last_q ? '0 : pos_q + cc20_pkg::POS_W'(1);
				if (last_q) begin
					msg_start_q <= 1'b1;
				end
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign st.need_block = msg_start_q || (pos_q == '0);
	assign st.out_free   = !out_valid_q || m_tready;
	assign m_tvalid      = out_valid_q;
	assign m_tdata       = out_data_q;
	assign m_tlast       = out_last_q;

	`CC20_ASSERT_NOW(a_start_pos, clk, arst_n, msg_start_q, pos_q == '0)

endmodule
